[sv/tsn_pkg.sv]
`default_nettype none

package tsn_pkg;

  localparam logic FuncChar = 1'b0;
  localparam logic FuncEnd  = 1'b1;

  localparam logic [7:0] ChSpace   = 8'h20;
  localparam logic [7:0] ChTab     = 8'h09;
  localparam logic [7:0] ChNewline = 8'h0a;
  localparam logic [7:0] ChPeriod  = 8'h2e;
  localparam logic [7:0] ChQuest   = 8'h3f;
  localparam logic [7:0] ChExclam  = 8'h21;
  localparam logic [7:0] ChComma   = 8'h2c;
  localparam logic [7:0] ChColon   = 8'h3a;
  localparam logic [7:0] ChLParen  = 8'h28;
  localparam logic [7:0] ChRParen  = 8'h29;
  localparam logic [7:0] ChSemi    = 8'h3b;
  localparam logic [7:0] ChLowerA  = 8'h61;
  localparam logic [7:0] ChLowerZ  = 8'h7a;
  localparam logic [7:0] CaseDelta = 8'h20;
  localparam logic [7:0] ChNul     = 8'h00;

  // One queued transaction: optional leading space, then the byte.
  typedef struct packed {
    logic       space;
    logic [7:0] ch;
    logic       last;
  } tsn_entry_t;

endpackage

`default_nettype wire

[sv/text_spacing_normalizer.sv]
// Flow: an accepted transaction is written into the queue, then loaded into the output register.
// Throughput: one input transaction per cycle while the queue is not full; an
//   inserted space is shown as its own output byte ahead of the byte, so a
//   long run of spaced bytes slows input once the QDepth-entry queue fills.
// Whitespace bytes produce no result; end of line produces one terminator.
// Reset (rst_ni low, asynchronous): queue and output emptied, line state cleared.
`default_nettype none

module text_spacing_normalizer #(
  parameter int QDepth = 4
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       push,
  output logic            full,
  input  wire logic       func_i,
  input  wire logic [7:0] char_in_i,
  output logic            empty,
  input  wire logic       pop,
  output logic [7:0]      char_out_o,
  output logic            is_last_o
);
  import tsn_pkg::*;

  logic       take, wr, rd, q_empty;
  tsn_entry_t wr_data, rd_data;

  assign take = push && !full;

  tsn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .take_i    (take),
    .func_i    (func_i),
    .char_in_i (char_in_i),
    .wr_o      (wr),
    .wr_data_o (wr_data)
  );

  tsn_fifo #(
    .Depth (QDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_i      (wr),
    .wr_data_i (wr_data),
    .full_o    (full),
    .rd_i      (rd),
    .rd_data_o (rd_data),
    .empty_o   (q_empty)
  );

  tsn_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_data_i   (rd_data),
    .q_rd_o     (rd),
    .pop_i      (pop),
    .empty_o    (empty),
    .char_out_o (char_out_o),
    .is_last_o  (is_last_o)
  );

endmodule

`default_nettype wire

[sv/tsn_front.sv]
`default_nettype none

module tsn_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               take_i,
  input  wire logic               func_i,
  input  wire logic [7:0]         char_in_i,
  output logic                    wr_o,
  output tsn_pkg::tsn_entry_t     wr_data_o
);
  import tsn_pkg::*;

  logic started_q, started_d;
  logic gap_q, gap_d;
  logic owed_q, owed_d;
  logic cap_q, cap_d;

  logic       is_end, is_ws, is_punct, is_sent, need_space;
  logic [7:0] cap_ch;

  always_comb begin
    is_end   = (func_i == FuncEnd);
    is_ws    = (char_in_i == ChSpace) || (char_in_i == ChTab) || (char_in_i == ChNewline);
    is_punct = (char_in_i == ChComma) || (char_in_i == ChColon) ||
               (char_in_i == ChPeriod) || (char_in_i == ChQuest) ||
               (char_in_i == ChExclam) || (char_in_i == ChLParen) ||
               (char_in_i == ChRParen) || (char_in_i == ChSemi);
    is_sent  = (char_in_i == ChPeriod) || (char_in_i == ChQuest) ||
               (char_in_i == ChExclam);
    cap_ch   = (cap_q && (char_in_i >= ChLowerA) && (char_in_i <= ChLowerZ)) ?
               (char_in_i - CaseDelta) : char_in_i;
    need_space = is_punct ? owed_q : (started_q && (gap_q || owed_q));

    wr_o             = take_i && (is_end || !is_ws);
    wr_data_o.space  = !is_end && need_space;
    wr_data_o.ch     = is_end ? ChNul : cap_ch;
    wr_data_o.last   = is_end;

    started_d = started_q;
    gap_d     = gap_q;
    owed_d    = owed_q;
    cap_d     = cap_q;
    if (take_i) begin
      if (is_end) begin
        started_d = 1'b0;
        gap_d     = 1'b0;
        owed_d    = 1'b0;
        cap_d     = 1'b1;
      end else if (is_ws) begin
        gap_d = gap_q || started_q;
      end else begin
        started_d = 1'b1;
        gap_d     = 1'b0;
        owed_d    = is_punct;
        cap_d     = is_sent;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q <= 1'b0;
      gap_q     <= 1'b0;
      owed_q    <= 1'b0;
      cap_q     <= 1'b1;
    end else begin
      started_q <= started_d;
      gap_q     <= gap_d;
      owed_q    <= owed_d;
      cap_q     <= cap_d;
    end
  end

endmodule

`default_nettype wire

[sv/tsn_fifo.sv]
`default_nettype none

module tsn_fifo #(
  parameter int Depth = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               wr_i,
  input  wire tsn_pkg::tsn_entry_t wr_data_i,
  output logic                    full_o,
  input  wire logic               rd_i,
  output tsn_pkg::tsn_entry_t     rd_data_o,
  output logic                    empty_o
);
  import tsn_pkg::*;

  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CW = $clog2(Depth + 1);

  tsn_entry_t     mem_q [Depth];
  logic [AW-1:0]  wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           do_wr, do_rd;

  always_comb begin
    full_o    = (cnt_q == CW'(Depth));
    empty_o   = (cnt_q == '0);
    do_wr     = wr_i && !full_o;
    do_rd     = rd_i && !empty_o;
    rd_data_o = mem_q[rptr_q];
    wptr_d    = wptr_q;
    rptr_d    = rptr_q;
    if (do_wr) begin
      wptr_d = (wptr_q == AW'(Depth - 1)) ? '0 : wptr_q + 1'b1;
    end
    if (do_rd) begin
      rptr_d = (rptr_q == AW'(Depth - 1)) ? '0 : rptr_q + 1'b1;
    end
    cnt_d = cnt_q;
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

`default_nettype wire

[sv/tsn_back.sv]
`default_nettype none

module tsn_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               q_empty_i,
  input  wire tsn_pkg::tsn_entry_t q_data_i,
  output logic                    q_rd_o,
  input  wire logic               pop_i,
  output logic                    empty_o,
  output logic [7:0]              char_out_o,
  output logic                    is_last_o
);
  import tsn_pkg::*;

  logic       valid_q, valid_d;
  logic       spdone_q, spdone_d;
  logic [7:0] ch_q, ch_d;
  logic       last_q, last_d;
  logic       load, take;

  always_comb begin
    load     = !valid_q || pop_i;
    take     = load && !q_empty_i;
    valid_d  = take ? 1'b1 : (valid_q && !pop_i);
    spdone_d = spdone_q;
    ch_d     = ch_q;
    last_d   = last_q;
    q_rd_o   = 1'b0;
    if (take) begin
      if (q_data_i.space && !spdone_q) begin
        ch_d     = ChSpace;
        last_d   = 1'b0;
        spdone_d = 1'b1;
      end else begin
        ch_d     = q_data_i.ch;
        last_d   = q_data_i.last;
        spdone_d = 1'b0;
        q_rd_o   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q   <= ch_d;
    last_q <= last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= 1'b0;
      spdone_q <= 1'b0;
    end else begin
      valid_q  <= valid_d;
      spdone_q <= spdone_d;
    end
  end

  assign empty_o    = !valid_q;
  assign char_out_o = ch_q;
  assign is_last_o  = last_q;

endmodule

`default_nettype wire

[sv/tsn_checker.sv]
`default_nettype none

module tsn_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       push,
  input wire logic       full,
  input wire logic       func_i,
  input wire logic [7:0] char_in_i,
  input wire logic       empty,
  input wire logic       pop,
  input wire logic [7:0] char_out_o,
  input wire logic       is_last_o
);
  import tsn_pkg::*;

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(char_out_o) && $stable(is_last_o))
    else $error("result changed while stalled");

  a_term_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && is_last_o |-> char_out_o == ChNul)
    else $error("terminator byte is not zero");

  a_no_ws_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> char_out_o != ChTab && char_out_o != ChNewline)
    else $error("tab or newline emitted");

  // Idle: no result shown and no transaction taken on the previous edge.
  a_ws_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty && !$past(push && !full) && !full && push && func_i == FuncChar &&
    char_in_i == ChSpace |=> empty)
    else $error("space byte into idle block produced a result");

endmodule

bind text_spacing_normalizer tsn_checker u_tsn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .push       (push),
  .full       (full),
  .func_i     (func_i),
  .char_in_i  (char_in_i),
  .empty      (empty),
  .pop        (pop),
  .char_out_o (char_out_o),
  .is_last_o  (is_last_o)
);

`default_nettype wire
